/* sv/ps2mct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants of the PS/2 mouse cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int BYTE_W  = 8;
  localparam int COORD_W = 12;
  localparam int BTN_W   = 3;
  localparam int DX_W    = 9;
  localparam int DY_W    = 10;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 12'd320;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 12'd200;
  localparam logic [COORD_W-1:0] POS_X_RST         = 12'd152;
  localparam logic [COORD_W-1:0] POS_Y_RST         = 12'd78;

  // Protocol bytes and header bit positions.
  localparam logic [BYTE_W-1:0] ACK_BYTE  = 8'hFA;
  localparam logic [BYTE_W-1:0] HDR_MASK  = 8'hC8;
  localparam logic [BYTE_W-1:0] HDR_MATCH = 8'h08;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;

  // One decoded packet, qualified by done.
  typedef struct packed {
    logic                    done;
    logic [BTN_W-1:0]        buttons;
    logic signed [DX_W-1:0]  delta_x;
    logic signed [DY_W-1:0]  delta_y;
  } pkt_t;

endpackage : ps2mct_pkg
`default_nettype wire

/* sv/ps2mct_in_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_in_if
// Byte channel into the tracker: valid/ready handshake with one raw byte.
// ----------------------------------------------------------------------------
interface ps2mct_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface : ps2mct_in_if
`default_nettype wire

/* sv/ps2mct_out_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_out_if
// Result channel of the tracker: buttons, movement and cursor position.
// ----------------------------------------------------------------------------
interface ps2mct_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         buttons;
  logic signed [8:0]  delta_x;
  logic signed [9:0]  delta_y;
  logic [11:0]        cursor_x;
  logic [11:0]        cursor_y;

  modport source (output valid, output buttons, output delta_x, output delta_y,
                  output cursor_x, output cursor_y, input ready);
  modport sink (input valid, input buttons, input delta_x, input delta_y,
                input cursor_x, input cursor_y, output ready);
endinterface : ps2mct_out_if
`default_nettype wire

/* sv/ps2mct_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_framer
// Waits for the acknowledge byte, then frames three-byte mouse packets.
// ----------------------------------------------------------------------------
module ps2mct_framer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          step,
  input  wire logic [ps2mct_pkg::BYTE_W-1:0] data_byte,
  output logic                               last_byte,
  output ps2mct_pkg::pkt_t                   pkt
);
  import ps2mct_pkg::*;

  typedef enum logic [1:0] {
    PH_WAIT_ACK,
    PH_HEADER,
    PH_MOVE_X,
    PH_MOVE_Y
  } phase_t;

  phase_t              phase_r;
  phase_t              phase_nxt;
  logic [BYTE_W-1:0]   header_r;
  logic [BYTE_W-1:0]   move_x_r;
  logic                hdr_ok;

  assign hdr_ok = (data_byte & HDR_MASK) == HDR_MATCH;

  // The byte on data_byte completes a packet if it is taken.
  assign last_byte = (phase_r == PH_MOVE_Y);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_WAIT_ACK: if (data_byte == ACK_BYTE) phase_nxt = PH_HEADER;
      PH_HEADER:   if (hdr_ok) phase_nxt = PH_MOVE_X;
      PH_MOVE_X:   phase_nxt = PH_MOVE_Y;
      PH_MOVE_Y:   phase_nxt = PH_HEADER;
      default:     phase_nxt = PH_WAIT_ACK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_ACK;
    end else if (step) begin
      phase_r <= phase_nxt;
      if (phase_r == PH_HEADER && hdr_ok) header_r <= data_byte;
      if (phase_r == PH_MOVE_X) move_x_r <= data_byte;
    end
  end

  // Y is negated so that a downward move comes out positive.
  always_comb begin
    pkt.done    = step && last_byte;
    pkt.buttons = header_r[BTN_W-1:0];
    pkt.delta_x = $signed({header_r[XSIGN_BIT], move_x_r});
    pkt.delta_y = -$signed({header_r[YSIGN_BIT], header_r[YSIGN_BIT], data_byte});
  end

endmodule : ps2mct_framer
`default_nettype wire

/* sv/ps2mct_cursor.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ps2mct_cursor
// Keeps the cursor position and applies each packet's movement with clamping.
// ----------------------------------------------------------------------------
module ps2mct_cursor #(
  parameter int CURSOR_SIZE = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  ps2mct_pkg::pkt_t                    pkt,
  input  wire logic [ps2mct_pkg::COORD_W-1:0] width,
  input  wire logic [ps2mct_pkg::COORD_W-1:0] height,
  output logic [ps2mct_pkg::COORD_W-1:0]      pos_x_nxt,
  output logic [ps2mct_pkg::COORD_W-1:0]      pos_y_nxt
);
  import ps2mct_pkg::*;

  localparam int SUM_W = COORD_W + 2;

  logic [COORD_W-1:0] pos_x_r;
  logic [COORD_W-1:0] pos_y_r;

  // Upper limit is size minus the cursor size, floored at zero.
  function automatic logic [COORD_W-1:0] clamp_pos(
    input logic [COORD_W-1:0]    pos,
    input logic signed [DY_W-1:0] mv,
    input logic [COORD_W-1:0]    size
  );
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] p;
    logic [COORD_W-1:0]      r;
    lim = $signed({2'b00, size}) - $signed(SUM_W'(CURSOR_SIZE));
    if (lim < 0) lim = '0;
    p = $signed({2'b00, pos}) + $signed({{(SUM_W-DY_W){mv[DY_W-1]}}, mv});
    if (p < 0) begin
      r = '0;
    end else if (p > lim) begin
      r = lim[COORD_W-1:0];
    end else begin
      r = p[COORD_W-1:0];
    end
    return r;
  endfunction

  assign pos_x_nxt = clamp_pos(pos_x_r, {pkt.delta_x[DX_W-1], pkt.delta_x}, width);
  assign pos_y_nxt = clamp_pos(pos_y_r, pkt.delta_y, height);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r <= POS_X_RST;
      pos_y_r <= POS_Y_RST;
    end else if (pkt.done) begin
      pos_x_r <= pos_x_nxt;
      pos_y_r <= pos_y_nxt;
    end
  end

endmodule : ps2mct_cursor
`default_nettype wire

/* sv/ps2_mouse_cursor_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Decodes PS/2 mouse packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
// Path: a byte is registered in the input stage at its transfer; the result of the third
//   packet byte is loaded into the output register when that byte leaves the input stage.
// Throughput: one byte per cycle from the single input register stage unless out_ch stalls.
// Reset: synchronous, active low; waits for the acknowledge byte, cursor at
//   (152, 78), screen size 320 x 200.
module ps2_mouse_cursor_tracker #(
  parameter int CURSOR_SIZE = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [ps2mct_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ps2mct_pkg::COORD_W-1:0]   cfg_wdata,
  ps2mct_in_if.sink                             in_ch,
  ps2mct_out_if.source                          out_ch
);
  import ps2mct_pkg::*;

  logic [COORD_W-1:0] width_r;
  logic [COORD_W-1:0] height_r;

  logic               in_vld_r;
  logic [BYTE_W-1:0]  in_byte_r;
  logic               adv;
  logic               last_byte;

  pkt_t               pkt;
  logic [COORD_W-1:0] pos_x_nxt;
  logic [COORD_W-1:0] pos_y_nxt;

  logic               out_vld_r;
  logic               out_vld_nxt;
  logic [BTN_W-1:0]   out_btn_r;
  logic signed [DX_W-1:0] out_dx_r;
  logic signed [DY_W-1:0] out_dy_r;
  logic [COORD_W-1:0] out_cx_r;
  logic [COORD_W-1:0] out_cy_r;

  // The input stage moves on unless it completes a packet while the output
  // register is still waiting for its transfer.
  assign adv = in_vld_r && (!last_byte || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SCREEN_WIDTH_RST;
      height_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  width_r  <= cfg_wdata;
        REG_SCREEN_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_byte_r <= in_ch.data_byte;
  end

  ps2mct_framer u_framer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (adv),
    .data_byte (in_byte_r),
    .last_byte (last_byte),
    .pkt       (pkt)
  );

  ps2mct_cursor #(
    .CURSOR_SIZE (CURSOR_SIZE)
  ) u_cursor (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt       (pkt),
    .width     (width_r),
    .height    (height_r),
    .pos_x_nxt (pos_x_nxt),
    .pos_y_nxt (pos_y_nxt)
  );

  assign out_vld_nxt = pkt.done || (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt.done) begin
      out_btn_r <= pkt.buttons;
      out_dx_r  <= pkt.delta_x;
      out_dy_r  <= pkt.delta_y;
      out_cx_r  <= pos_x_nxt;
      out_cy_r  <= pos_y_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.buttons  = out_btn_r;
  assign out_ch.delta_x  = out_dx_r;
  assign out_ch.delta_y  = out_dy_r;
  assign out_ch.cursor_x = out_cx_r;
  assign out_ch.cursor_y = out_cy_r;

`ifndef ASSERT_OFF
  // A held input byte is never overwritten while it waits.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !adv |=> in_vld_r && $stable(in_byte_r))
    else $error("input byte lost while stalled");

  // A packet completes only when a byte moves on and the output slot is free or being taken.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    pkt.done |-> adv && (!out_vld_r || out_ch.ready))
    else $error("packet completed while output slot busy");

  a_cx_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cx_r == '0) ||
      ({1'b0, out_cx_r} + (COORD_W+1)'(CURSOR_SIZE) <= {1'b0, width_r}))
    else $error("cursor x beyond screen limit");

  a_cy_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_cy_r == '0) ||
      ({1'b0, out_cy_r} + (COORD_W+1)'(CURSOR_SIZE) <= {1'b0, height_r}))
    else $error("cursor y beyond screen limit");
`endif

endmodule : ps2_mouse_cursor_tracker
`default_nettype wire
